// ===== rtl/sbnd_pkg.sv =====
`timescale 1ns / 1ps

package sbnd_pkg;

    localparam int FADE_STEPS   = 10;
    localparam int LEVEL_W      = 7;
    localparam int MINUTE_W     = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;

    localparam int LEVEL_MAX    = 100;
    localparam int STEP_W       = $clog2(FADE_STEPS);
    localparam int MAG_W        = $clog2(LEVEL_MAX * (FADE_STEPS - 1) + 1);
    localparam int RECIP_SHIFT  = 20;
    localparam int RECIP_W      = RECIP_SHIFT;
    localparam int RECIP_MUL    = ((2 ** RECIP_SHIFT) + FADE_STEPS - 1) / FADE_STEPS;
    localparam int PROD_W       = MAG_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MINUTE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MINUTE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_LEVEL   = 2'd3;

    localparam logic [MINUTE_W-1:0] START_MINUTE_RST = 11'd1290;
    localparam logic [MINUTE_W-1:0] END_MINUTE_RST   = 11'd390;
    localparam logic [LEVEL_W-1:0]  NIGHT_LEVEL_RST  = 7'd15;
    localparam logic [LEVEL_W-1:0]  DAY_LEVEL_RST    = 7'd80;
    localparam logic [LEVEL_W-1:0]  LEVEL_HI         = 7'd100;
    localparam logic [LEVEL_W-1:0]  LEVEL_LO         = 7'd1;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic step_mul;
        logic emit_step;
        logic emit_final;
    } cmd_t;

    typedef struct packed {
        logic fade;
        logic has_steps;
        logic more_steps;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/sbnd_in_if.sv =====
`timescale 1ns / 1ps

interface sbnd_in_if;
    logic                            valid;
    logic                            ready;
    logic [sbnd_pkg::MINUTE_W-1:0]   minute_of_day;
    logic                            time_valid;
    logic                            alarm_active;
    logic                            user_idle;
    logic [sbnd_pkg::LEVEL_W-1:0]    manual_level;

    modport source (
        output valid, minute_of_day, time_valid, alarm_active, user_idle, manual_level,
        input  ready
    );

    modport sink (
        input  valid, minute_of_day, time_valid, alarm_active, user_idle, manual_level,
        output ready
    );
endinterface

// ===== rtl/sbnd_out_if.sv =====
`timescale 1ns / 1ps

interface sbnd_out_if;
    logic                         valid;
    logic                         ready;
    logic [sbnd_pkg::LEVEL_W-1:0] level;
    logic                         last;
    logic                         night_mode;

    modport source (
        output valid, level, last, night_mode,
        input  ready
    );

    modport sink (
        input  valid, level, last, night_mode,
        output ready
    );
endinterface

// ===== rtl/sbnd_ctrl.sv =====
`timescale 1ns / 1ps

module sbnd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sbnd_pkg::status_t status,
    output sbnd_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_EMIT,
        S_FINAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (!status.fade)
                    state_next = S_IDLE;
                else if (status.has_steps)
                    state_next = S_MUL;
                else
                    state_next = S_FINAL;
            end
            S_MUL:
            begin
                cmd.step_mul = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    state_next    = status.more_steps ? S_MUL : S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/sbnd_datapath.sv =====
`timescale 1ns / 1ps

module sbnd_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sbnd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbnd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [sbnd_pkg::MINUTE_W-1:0]     in_minute_of_day,
    input  logic                              in_time_valid,
    input  logic                              in_alarm_active,
    input  logic                              in_user_idle,
    input  logic [sbnd_pkg::LEVEL_W-1:0]      in_manual_level,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [sbnd_pkg::LEVEL_W-1:0]      out_level,
    output logic                              out_last,
    output logic                              out_night_mode,
    input  sbnd_pkg::cmd_t                    cmd,
    output sbnd_pkg::status_t                 status
);

    localparam int LW = sbnd_pkg::LEVEL_W;
    localparam int MW = sbnd_pkg::MINUTE_W;

    // configuration
    logic          night_enabled_reg;
    logic [MW-1:0] start_minute_reg;
    logic [MW-1:0] end_minute_reg;
    logic [LW-1:0] night_level_reg;

    // latched request
    logic [MW-1:0] minute_reg;
    logic          tvalid_reg;
    logic          alarm_reg;
    logic          idle_reg;
    logic [LW-1:0] manual_reg;

    // block state
    logic          alarm_held_reg;
    logic          night_applied_reg;
    logic [LW-1:0] driven_level_reg;
    logic [LW-1:0] day_lvl_reg;

    // fade datapath
    logic [LW-1:0]                     from_reg;
    logic [LW-1:0]                     to_reg;
    logic                              want_reg;
    logic                              neg_reg;
    logic [LW-1:0]                     absdiff_reg;
    logic [sbnd_pkg::MAG_W-1:0]        mag_reg;
    logic [sbnd_pkg::STEP_W-1:0]       step_reg;
    logic [sbnd_pkg::PROD_W-1:0]       prod_reg;

    // result register
    logic          out_valid_reg;
    logic [LW-1:0] out_level_reg;
    logic          out_last_reg;
    logic          out_night_reg;

    logic          in_window;
    logic          want;
    logic          fade;
    logic [LW-1:0] target;
    logic [LW-1:0] to_val;
    logic [LW-1:0] from_val;
    logic [LW-1:0] manual_sat;
    logic [LW-1:0] quot;
    logic [LW:0]   lvl_wide;
    logic          out_free;

    always_comb
    begin
        if (start_minute_reg == end_minute_reg)
            in_window = 1'b0;
        else if (start_minute_reg < end_minute_reg)
            in_window = (minute_reg >= start_minute_reg) && (minute_reg < end_minute_reg);
        else
            in_window = (minute_reg >= start_minute_reg) || (minute_reg < end_minute_reg);
    end

    assign want = night_enabled_reg && tvalid_reg && in_window;

    // fade needed: no alarm, not tracking, an edge or an alarm end, user present
    assign fade = !alarm_reg && (want || night_applied_reg)
                  && ((want != night_applied_reg) || alarm_held_reg) && !idle_reg;

    assign target = want ? night_level_reg : day_lvl_reg;

    always_comb
    begin
        if (target < sbnd_pkg::LEVEL_LO)
            to_val = sbnd_pkg::LEVEL_LO;
        else if (target > sbnd_pkg::LEVEL_HI)
            to_val = sbnd_pkg::LEVEL_HI;
        else
            to_val = target;
    end

    assign from_val   = (driven_level_reg != '0) ? driven_level_reg : to_val;
    assign manual_sat = (manual_reg > sbnd_pkg::LEVEL_HI) ? sbnd_pkg::LEVEL_HI : manual_reg;

    assign quot     = prod_reg[sbnd_pkg::RECIP_SHIFT +: LW];
    assign lvl_wide = neg_reg ? ({1'b0, from_reg} - {1'b0, quot})
                              : ({1'b0, from_reg} + {1'b0, quot});

    assign out_free = !out_valid_reg || out_ready;

    assign status.fade       = fade;
    assign status.has_steps  = (from_val != to_val);
    assign status.more_steps = (step_reg != sbnd_pkg::STEP_W'(sbnd_pkg::FADE_STEPS - 1));
    assign status.out_free   = out_free;

    assign out_valid      = out_valid_reg;
    assign out_level      = out_level_reg;
    assign out_last       = out_last_reg;
    assign out_night_mode = out_night_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            night_enabled_reg <= 1'b0;
            start_minute_reg  <= sbnd_pkg::START_MINUTE_RST;
            end_minute_reg    <= sbnd_pkg::END_MINUTE_RST;
            night_level_reg   <= sbnd_pkg::NIGHT_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbnd_pkg::CFG_NIGHT_ENABLED: night_enabled_reg <= cfg_data[0];
                sbnd_pkg::CFG_START_MINUTE:  start_minute_reg  <= cfg_data[MW-1:0];
                sbnd_pkg::CFG_END_MINUTE:    end_minute_reg    <= cfg_data[MW-1:0];
                sbnd_pkg::CFG_NIGHT_LEVEL:   night_level_reg   <= cfg_data[LW-1:0];
                default:                     night_enabled_reg <= night_enabled_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            minute_reg <= in_minute_of_day;
            tvalid_reg <= in_time_valid;
            alarm_reg  <= in_alarm_active;
            idle_reg   <= in_user_idle;
            manual_reg <= in_manual_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_held_reg    <= 1'b0;
            night_applied_reg <= 1'b0;
            driven_level_reg  <= '0;
            day_lvl_reg       <= sbnd_pkg::DAY_LEVEL_RST;
        end
        else if (cmd.eval)
        begin
            if (alarm_reg)
                alarm_held_reg <= 1'b1;
            else
            begin
                alarm_held_reg <= 1'b0;
                if (!want && !night_applied_reg)
                begin
                    if (manual_reg != '0)
                    begin
                        day_lvl_reg      <= manual_sat;
                        driven_level_reg <= manual_sat;
                    end
                end
                else if ((want != night_applied_reg) || alarm_held_reg)
                begin
                    night_applied_reg <= want;
                    driven_level_reg  <= idle_reg ? '0 : to_val;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            from_reg    <= from_val;
            to_reg      <= to_val;
            want_reg    <= want;
            neg_reg     <= (to_val < from_val);
            absdiff_reg <= (to_val < from_val) ? (from_val - to_val) : (to_val - from_val);
            mag_reg     <= sbnd_pkg::MAG_W'((to_val < from_val) ? (from_val - to_val)
                                                                 : (to_val - from_val));
            step_reg    <= sbnd_pkg::STEP_W'(1);
        end
        else if (cmd.emit_step)
        begin
            mag_reg  <= mag_reg + sbnd_pkg::MAG_W'(absdiff_reg);
            step_reg <= step_reg + sbnd_pkg::STEP_W'(1);
        end
        if (cmd.step_mul)
            prod_reg <= sbnd_pkg::PROD_W'(mag_reg)
                        * sbnd_pkg::PROD_W'(sbnd_pkg::RECIP_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_step || cmd.emit_final)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            out_level_reg <= lvl_wide[LW-1:0];
            out_last_reg  <= 1'b0;
            out_night_reg <= want_reg;
        end
        else if (cmd.emit_final)
        begin
            out_level_reg <= to_reg;
            out_last_reg  <= 1'b1;
            out_night_reg <= want_reg;
        end
    end

endmodule

// ===== rtl/scheduled_backlight_night_dimmer_top.sv =====
`timescale 1ns / 1ps

// Scheduled backlight night dimmer.
// Requests arrive on in_ch (minute of day, time valid, alarm, user idle,
// manual level); levels leave on out_ch, none, one or several per request,
// the final level of a fade marked with last. Registers are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while the
// block is idle, the block itself does not enforce it.
// One request is handled at a time. A fade with intermediate levels runs
// the step loop of the sequencer: S_MUL through the reciprocal multiplier
// that replaces the divide by FADE_STEPS, then S_EMIT to emit. A fade that
// only drives the target goes from S_EVAL straight to S_FINAL.
// A level waits in the output register while out_ch.ready is low; the
// sequencer holds until it is taken, and in_ch.ready stays low until the
// final level of the fade has entered the output register.
// Reset (rst_n, async, active low) restores the register defaults, clears
// the alarm and night flags, marks the driven level unknown and sets the
// day level to 80.
module scheduled_backlight_night_dimmer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sbnd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbnd_pkg::CFG_DATA_W-1:0]   cfg_data,
    sbnd_in_if.sink                           in_ch,
    sbnd_out_if.source                        out_ch
);

    sbnd_pkg::cmd_t    cmd;
    sbnd_pkg::status_t status;

    sbnd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sbnd_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_minute_of_day (in_ch.minute_of_day),
        .in_time_valid    (in_ch.time_valid),
        .in_alarm_active  (in_ch.alarm_active),
        .in_user_idle     (in_ch.user_idle),
        .in_manual_level  (in_ch.manual_level),
        .out_ready        (out_ch.ready),
        .out_valid        (out_ch.valid),
        .out_level        (out_ch.level),
        .out_last         (out_ch.last),
        .out_night_mode   (out_ch.night_mode),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
